// ===== hw/rtl/brc_pkg.sv =====
`default_nettype none
package brc_pkg;
   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_MUL,
      ST_T_DIV,
      ST_P_SQ,
      ST_P_X1,
      ST_P_X2,
      ST_P_X1B,
      ST_P_X2B,
      ST_P_B4,
      ST_P_B7,
      ST_P_DIV,
      ST_P_F1,
      ST_P_F2,
      ST_P_F3,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } alu_rsp_type;

   localparam logic [1:0] REG_CALIB_A = 2'd0;
   localparam logic [1:0] REG_CALIB_B = 2'd1;
   localparam logic [1:0] REG_CALIB_C = 2'd2;
   localparam logic [1:0] REG_OSS     = 2'd3;

   localparam logic [31:0] B6_OFFSET = 32'd4000;
   localparam logic [31:0] P_SCALE   = 32'd50000;
   localparam logic [31:0] SIGN32    = 32'h8000_0000;
   localparam logic [31:0] P_C1      = 32'd3038;
   localparam logic [31:0] P_C2      = 32'hFFFF_E343;
   localparam logic [31:0] P_C3      = 32'd3791;
   localparam logic [31:0] B4_BIAS   = 32'd32768;
endpackage
`default_nettype wire

// ===== hw/rtl/brc_if.sv =====
`default_nettype none
interface brc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [18:0] raw_value;
   modport source (output valid, cmd, raw_value, input ready);
   modport sink (input valid, cmd, raw_value, output ready);
endinterface

interface brc_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] value;
   logic               div_fault;
   modport source (output valid, kind, value, div_fault, input ready);
   modport sink (input valid, kind, value, div_fault, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/barometer_raw_compensation.sv =====
`default_nettype none
// a zero divisor skips the divide and the remaining steps and ends the item with a fault result
// throughput: one item at a time; each multiply and divide runs on the
// shared bit-serial unit, eleven such operations for a pressure item, two for temperature;
// the next input transfer is accepted only once the result has been transferred
// reset: synchronous, clears control, calibration, oversampling and stored b5 to zero
module barometer_raw_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   brc_req_if.sink          req,
   brc_rsp_if.source        rsp,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   brc_pkg::state_type state_ff, state_in;
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;
   logic [31:0] b5_ff, b5_in;
   logic        cmd_ff;
   logic [18:0] raw_ff;
   logic [31:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic        neg_ff, neg_in;
   logic        wait_ff, wait_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_value_ff, out_value_in;
   logic        out_fault_ff, out_fault_in;
   brc_pkg::alu_req_type alu_req;
   brc_pkg::alu_rsp_type alu_rsp;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, rawx, res;

   assign ac1  = {{16{cal_a_ff[63]}}, cal_a_ff[63:48]};
   assign ac2  = {{16{cal_a_ff[47]}}, cal_a_ff[47:32]};
   assign ac3  = {{16{cal_a_ff[31]}}, cal_a_ff[31:16]};
   assign ac4  = {16'd0, cal_a_ff[15:0]};
   assign ac5  = {16'd0, cal_b_ff[63:48]};
   assign ac6  = {16'd0, cal_b_ff[47:32]};
   assign b1   = {{16{cal_b_ff[31]}}, cal_b_ff[31:16]};
   assign b2   = {{16{cal_b_ff[15]}}, cal_b_ff[15:0]};
   assign mc   = {{16{cal_c_ff[31]}}, cal_c_ff[31:16]};
   assign md   = {{16{cal_c_ff[15]}}, cal_c_ff[15:0]};
   assign rawx = {13'd0, raw_ff};
   assign res  = alu_rsp.result;

   brc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign req.ready = (state_ff == brc_pkg::ST_IDLE) && !out_valid_ff;

   always_comb begin
      state_in = state_ff;
      if (state_ff == brc_pkg::ST_IDLE) begin
         if (req.valid && req.ready) begin
            state_in = req.cmd ? brc_pkg::ST_P_SQ : brc_pkg::ST_T_MUL;
         end
      end else if (state_ff == brc_pkg::ST_DONE) begin
         if (!out_valid_ff) begin
            state_in = brc_pkg::ST_IDLE;
         end
      end else if (wait_ff && alu_rsp.done) begin
         case (state_ff)
            brc_pkg::ST_T_MUL: begin
               state_in = brc_pkg::ST_T_DIV;
            end
            brc_pkg::ST_T_DIV: state_in = brc_pkg::ST_DONE;
            brc_pkg::ST_P_SQ:  state_in = brc_pkg::ST_P_X1;
            brc_pkg::ST_P_X1:  state_in = brc_pkg::ST_P_X2;
            brc_pkg::ST_P_X2:  state_in = brc_pkg::ST_P_X1B;
            brc_pkg::ST_P_X1B: state_in = brc_pkg::ST_P_X2B;
            brc_pkg::ST_P_X2B: state_in = brc_pkg::ST_P_B4;
            brc_pkg::ST_P_B4:  state_in = brc_pkg::ST_P_B7;
            brc_pkg::ST_P_B7:  state_in = brc_pkg::ST_P_DIV;
            brc_pkg::ST_P_DIV: state_in = brc_pkg::ST_P_F1;
            brc_pkg::ST_P_F1:  state_in = brc_pkg::ST_P_F2;
            brc_pkg::ST_P_F2:  state_in = brc_pkg::ST_P_F3;
            brc_pkg::ST_P_F3:  state_in = brc_pkg::ST_DONE;
            default:           state_in = brc_pkg::ST_IDLE;
         endcase
         // divide setup may skip straight to a fault result
         if (state_ff == brc_pkg::ST_T_MUL &&
             $unsigned($signed(res) >>> 15) + md == 32'd0) begin
            state_in = brc_pkg::ST_DONE;
         end
         if (state_ff == brc_pkg::ST_P_B7 && r2_ff == 32'd0) begin
            state_in = brc_pkg::ST_DONE;
         end
      end
   end

   always_comb begin
      logic [31:0] t, d, n, x3, b3, p;
      r0_in = r0_ff;
      r1_in = r1_ff;
      r2_in = r2_ff;
      r3_in = r3_ff;
      neg_in = neg_ff;
      b5_in = b5_ff;
      wait_in = wait_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_fault_in = out_fault_ff;
      alu_req.start = 1'b0;
      alu_req.op = brc_pkg::OP_MUL;
      alu_req.a = '0;
      alu_req.b = '0;
      t = '0; d = '0; n = '0; x3 = '0; b3 = '0; p = '0;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == brc_pkg::ST_IDLE) begin
         if (req.valid && req.ready) begin
            wait_in = 1'b1;
            alu_req.start = 1'b1;
            if (req.cmd) begin
               r0_in = b5_ff - brc_pkg::B6_OFFSET;
               alu_req.a = b5_ff - brc_pkg::B6_OFFSET;
               alu_req.b = b5_ff - brc_pkg::B6_OFFSET;
            end else begin
               alu_req.a = {13'd0, req.raw_value} - ac6;
               alu_req.b = ac5;
            end
         end
      end else if (wait_ff && alu_rsp.done) begin
         alu_req.start = 1'b1;
         case (state_ff)
            brc_pkg::ST_T_MUL: begin
               t = $signed(res) >>> 15;
               d = t + md;
               r1_in = t;
               if (d == 32'd0) begin
                  alu_req.start = 1'b0;
                  wait_in = 1'b0;
                  out_valid_in = 1'b1;
                  out_value_in = '0;
                  out_fault_in = 1'b1;
               end else begin
                  n = mc << 11;
                  neg_in = n[31] ^ d[31];
                  alu_req.op = brc_pkg::OP_DIV;
                  alu_req.a = n[31] ? 32'd0 - n : n;
                  alu_req.b = d[31] ? 32'd0 - d : d;
               end
            end
            brc_pkg::ST_T_DIV: begin
               alu_req.start = 1'b0;
               wait_in = 1'b0;
               t = r1_ff + (neg_ff ? 32'd0 - res : res);
               b5_in = t;
               out_valid_in = 1'b1;
               out_value_in = $signed(t + 32'd8) >>> 4;
               out_fault_in = 1'b0;
            end
            brc_pkg::ST_P_SQ: begin
               r1_in = $signed(res) >>> 12;
               alu_req.a = b2;
               alu_req.b = $signed(res) >>> 12;
            end
            brc_pkg::ST_P_X1: begin
               r2_in = $signed(res) >>> 11;
               alu_req.a = ac2;
               alu_req.b = r0_ff;
            end
            brc_pkg::ST_P_X2: begin
               x3 = r2_ff + $unsigned($signed(res) >>> 11);
               b3 = $signed(((ac1 * 32'd4 + x3) << oss_ff) + 32'd2) >>> 2;
               r3_in = rawx - b3;
               alu_req.a = ac3;
               alu_req.b = r0_ff;
            end
            brc_pkg::ST_P_X1B: begin
               r2_in = $signed(res) >>> 13;
               alu_req.a = b1;
               alu_req.b = r1_ff;
            end
            brc_pkg::ST_P_X2B: begin
               x3 = $signed(r2_ff + $unsigned($signed(res) >>> 16) + 32'd2) >>> 2;
               alu_req.a = ac4;
               alu_req.b = x3 + brc_pkg::B4_BIAS;
            end
            brc_pkg::ST_P_B4: begin
               r2_in = res >> 15;
               alu_req.a = r3_ff;
               alu_req.b = brc_pkg::P_SCALE >> oss_ff;
            end
            brc_pkg::ST_P_B7: begin
               if (r2_ff == 32'd0) begin
                  alu_req.start = 1'b0;
                  wait_in = 1'b0;
                  out_valid_in = 1'b1;
                  out_value_in = '0;
                  out_fault_in = 1'b1;
               end else begin
                  neg_in = res[31];
                  alu_req.op = brc_pkg::OP_DIV;
                  alu_req.a = (res < brc_pkg::SIGN32) ? (res << 1) : res;
                  alu_req.b = r2_ff;
               end
            end
            brc_pkg::ST_P_DIV: begin
               p = neg_ff ? (res << 1) : res;
               r0_in = p;
               alu_req.a = $signed(p) >>> 8;
               alu_req.b = $signed(p) >>> 8;
            end
            brc_pkg::ST_P_F1: begin
               alu_req.a = res;
               alu_req.b = brc_pkg::P_C1;
            end
            brc_pkg::ST_P_F2: begin
               r1_in = $signed(res) >>> 16;
               alu_req.a = brc_pkg::P_C2;
               alu_req.b = r0_ff;
            end
            brc_pkg::ST_P_F3: begin
               alu_req.start = 1'b0;
               wait_in = 1'b0;
               out_valid_in = 1'b1;
               out_value_in = r0_ff + $unsigned($signed(r1_ff +
                  $unsigned($signed(res) >>> 16) + brc_pkg::P_C3) >>> 4);
               out_fault_in = 1'b0;
            end
            default: begin
               alu_req.start = 1'b0;
               wait_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brc_pkg::ST_IDLE;
         cal_a_ff     <= '0;
         cal_b_ff     <= '0;
         cal_c_ff     <= '0;
         oss_ff       <= '0;
         b5_ff        <= '0;
         wait_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b5_ff        <= b5_in;
         wait_ff      <= wait_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            case (csr_index)
               brc_pkg::REG_CALIB_A: cal_a_ff <= csr_data;
               brc_pkg::REG_CALIB_B: cal_b_ff <= csr_data;
               brc_pkg::REG_CALIB_C: cal_c_ff <= csr_data[31:0];
               brc_pkg::REG_OSS:     oss_ff   <= csr_data[1:0];
               default: ;
            endcase
         end
      end
      if (req.valid && req.ready) begin
         cmd_ff <= req.cmd;
         raw_ff <= req.raw_value;
      end
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
      r3_ff        <= r3_in;
      neg_ff       <= neg_in;
      out_value_ff <= out_value_in;
      out_fault_ff <= out_fault_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.kind      = cmd_ff;
   assign rsp.value     = out_value_ff;
   assign rsp.div_fault = out_fault_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/brc_alu.sv =====
`default_nettype none
// bit-serial 32x32 wrap multiply (shift-add) and 32/32 unsigned restoring divide
module brc_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire brc_pkg::alu_req_type  req,
   output brc_pkg::alu_rsp_type       rsp
);
   logic [31:0] acc_ff, acc_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   brc_pkg::op_type op_ff, op_in;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      rem_sh  = {acc_ff, a_ff[31]};
      rem_sub = rem_sh - {1'b0, b_ff};
      if (req.start) begin
         acc_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
         op_in   = req.op;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff == brc_pkg::OP_MUL) begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[30:0], 1'b0};
            b_in = {1'b0, b_ff[31:1]};
         end else begin
            if (!rem_sub[32]) begin
               acc_in = rem_sub[31:0];
               a_in   = {a_ff[30:0], 1'b1};
            end else begin
               acc_in = rem_sh[31:0];
               a_in   = {a_ff[30:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      op_ff  <= op_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = (op_ff == brc_pkg::OP_MUL) ? acc_ff : a_ff;
endmodule
`default_nettype wire

// ===== sim/brc_checker.sv =====
module brc_checker (
   input wire logic  clock,
   input wire logic  reset,
   brc_req_if.sink   req_mon,
   brc_rsp_if.sink   rsp_mon,
   input wire logic        csr_write,
   input wire logic [1:0]  csr_index,
   input wire logic [63:0] csr_data,
   output int        errors,
   output int        pending,
   output int        n_temp,
   output int        n_press,
   output int        n_fault
);
   typedef struct {
      logic        kind;
      logic [31:0] value;
      logic        div_fault;
   } comp_result_type;

   logic [63:0] cal_a, cal_b;
   logic [31:0] cal_c;
   logic [1:0]  oss;
   logic [31:0] b5;
   comp_result_type expected_q[$];

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sra(logic [31:0] v, int s);
      return $unsigned($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] sdiv32(logic [31:0] n, logic [31:0] d);
      logic [31:0] mn, md, q;
      mn = n[31] ? -n : n;
      md = d[31] ? -d : d;
      q = mn / md;
      return (n[31] != d[31]) ? -q : q;
   endfunction

   task automatic compensate(input logic cmd, input logic [18:0] raw);
      comp_result_type r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, rw;
      logic [31:0] x1, x2, x3, d, b6, sq, b3, b4, b7, p;
      ac1 = sx16(cal_a[63:48]); ac2 = sx16(cal_a[47:32]);
      ac3 = sx16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
      ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
      b1 = sx16(cal_b[31:16]); b2 = sx16(cal_b[15:0]);
      mc = sx16(cal_c[31:16]); md = sx16(cal_c[15:0]);
      rw = {13'd0, raw};
      r.kind = cmd; r.value = '0; r.div_fault = 1'b0;
      if (!cmd) begin
         x1 = sra((rw - ac6) * ac5, 15);
         d = x1 + md;
         if (d == 0) r.div_fault = 1'b1;
         else begin
            x2 = sdiv32(mc << 11, d);
            b5 = x1 + x2;
            r.value = sra(b5 + 32'd8, 4);
         end
      end else begin
         b6 = b5 - brc_pkg::B6_OFFSET;
         sq = sra(b6 * b6, 12);
         x1 = sra(b2 * sq, 11);
         x2 = sra(ac2 * b6, 11);
         x3 = x1 + x2;
         b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
         x1 = sra(ac3 * b6, 13);
         x2 = sra(b1 * sq, 16);
         x3 = sra(x1 + x2 + 32'd2, 2);
         b4 = (ac4 * (x3 + brc_pkg::B4_BIAS)) >> 15;
         b7 = (rw - b3) * (brc_pkg::P_SCALE >> oss);
         if (b4 == 0) r.div_fault = 1'b1;
         else begin
            if (b7 < brc_pkg::SIGN32) p = (b7 << 1) / b4;
            else p = (b7 / b4) << 1;
            x1 = sra(p, 8) * sra(p, 8);
            x1 = sra(x1 * brc_pkg::P_C1, 16);
            x2 = sra(brc_pkg::P_C2 * p, 16);
            r.value = p + sra(x1 + x2 + brc_pkg::P_C3, 4);
         end
      end
      expected_q.push_back(r);
   endtask

   assign pending = expected_q.size();

   always @(posedge clock) begin
      comp_result_type e;
      if (reset) begin
         cal_a <= '0; cal_b <= '0; cal_c <= '0; oss <= '0; b5 = '0;
         errors <= 0; n_temp <= 0; n_press <= 0; n_fault <= 0;
         expected_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               brc_pkg::REG_CALIB_A: cal_a <= csr_data;
               brc_pkg::REG_CALIB_B: cal_b <= csr_data;
               brc_pkg::REG_CALIB_C: cal_c <= csr_data[31:0];
               brc_pkg::REG_OSS:     oss <= csr_data[1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: expected no transfer, got kind %0d value %0d", $time,
                        rsp_mon.kind, rsp_mon.value);
               errors <= errors + 1;
            end else begin
               e = expected_q.pop_front();
               if (e.kind !== rsp_mon.kind || e.value !== rsp_mon.value ||
                   e.div_fault !== rsp_mon.div_fault) begin
                  $display("%0t: expected kind %0d value %0d fault %0d, got %0d %0d %0d",
                           $time, e.kind, $signed(e.value), e.div_fault,
                           rsp_mon.kind, rsp_mon.value, rsp_mon.div_fault);
                  errors <= errors + 1;
               end
               if (e.kind) n_press <= n_press + 1; else n_temp <= n_temp + 1;
               if (e.div_fault) n_fault <= n_fault + 1;
            end
         end
         if (req_mon.valid && req_mon.ready) compensate(req_mon.cmd, req_mon.raw_value);
      end
   end
endmodule

// ===== sim/tb.sv =====
module tb;
   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic [1:0] csr_index = 0;
   logic [63:0] csr_data = 0;
   int errors, pending, n_temp, n_press, n_fault;
   bit hold_long = 0;

   brc_req_if req_ch ();
   brc_rsp_if rsp_ch ();

   barometer_raw_compensation u_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   brc_checker u_chk (
      .clock(clock), .reset(reset), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending), .n_temp(n_temp), .n_press(n_press),
      .n_fault(n_fault)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0; req_ch.cmd = 0; req_ch.raw_value = 0;
      rsp_ch.ready = 0;
   end

   // receiver: random stalls, long hold-offs while requested
   initial begin
      int w;
      @(negedge clock);
      forever begin
         w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         if (hold_long) w = 3000;
         if (w > 0) begin
            rsp_ch.ready <= 0;
            repeat (w) @(negedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send(input logic cmd, input logic [18:0] raw);
      int w;
      w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
         req_ch.valid <= 0;
         repeat (w) @(negedge clock);
      end
      req_ch.valid <= 1; req_ch.cmd <= cmd; req_ch.raw_value <= raw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_ch.valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
   endtask

   task automatic csr(input logic [1:0] idx, input logic [63:0] data);
      csr_write = 1; csr_index = idx; csr_data = data;
      @(negedge clock);
      csr_write = 0;
   endtask

   function automatic logic [63:0] r64();
      return {$urandom, $urandom};
   endfunction

   // typical calibration words with random jitter
   task automatic set_typical;
      logic [15:0] j;
      j = 16'($urandom_range(0, 63));
      csr(brc_pkg::REG_CALIB_A, {16'd408 + j, 16'hFFC8, 16'hC6A3 + j, 16'd32741 + j});
      csr(brc_pkg::REG_CALIB_B, {16'd32757 - j, 16'd23153 + j, 16'd6190, 16'd4});
      csr(brc_pkg::REG_CALIB_C, {32'd0, 16'h8000 ^ j, 16'd2868 + j});
      csr(brc_pkg::REG_OSS, 64'($urandom_range(0, 3)));
   endtask

   initial begin
      logic [18:0] raw;
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // pressure before any temperature, all-zero calibration (both divisors zero)
      send(1, 19'h7FFFF);
      send(0, 0);
      drain();
      set_typical();
      csr(brc_pkg::REG_OSS, 0);
      send(0, 27898); send(1, 23843); send(0, 0); send(1, 0);
      send(0, 19'h7FFFF); send(1, 19'h7FFFF); send(0, 19'h55555); send(1, 19'h2AAAA);
      drain();
      csr(brc_pkg::REG_OSS, 3);
      send(0, 27898); send(1, 19'h7FFFF); send(1, 0);
      drain();
      // extremes of calibration words
      csr(brc_pkg::REG_CALIB_A, 64'hFFFF_FFFF_FFFF_FFFF);
      csr(brc_pkg::REG_CALIB_B, 64'hFFFF_FFFF_FFFF_FFFF);
      csr(brc_pkg::REG_CALIB_C, 64'hFFFF_FFFF_FFFF_FFFF);
      send(0, 19'h7FFFF); send(1, 19'h7FFFF); send(0, 0); send(1, 0);
      drain();
      csr(brc_pkg::REG_CALIB_A, 64'h8000_8000_8000_0000);
      csr(brc_pkg::REG_CALIB_B, 64'h0000_0000_8000_8000);
      csr(brc_pkg::REG_CALIB_C, 64'h8000_0000); // md zero, ac5 zero: zero temperature divisor
      send(0, 1234); send(1, 5678);
      drain();
      // many items held back at the receiver
      set_typical();
      hold_long = 1;
      for (int i = 0; i < 6; i++) send(i[0], 19'($urandom));
      hold_long = 0;
      drain();
      for (int ph = 0; ph < 9; ph++) begin
         if (ph % 3 == 2) begin
            csr(brc_pkg::REG_CALIB_A, r64()); csr(brc_pkg::REG_CALIB_B, r64());
            csr(brc_pkg::REG_CALIB_C, r64()); csr(brc_pkg::REG_OSS, 64'($urandom));
         end else set_typical();
         for (int i = 0; i < 80; i++) begin
            if ($urandom_range(0, 9) < 8) begin
               raw = 19'($urandom_range(20000, 34000));
               send(0, $urandom_range(0, 7) == 0 ? 19'($urandom) : raw);
               raw = 19'($urandom_range(15000, 200000));
               send(1, $urandom_range(0, 7) == 0 ? 19'($urandom) : raw);
            end else send(1'($urandom), 19'($urandom));
         end
         drain();
      end
      $display("tb: %0d temperature and %0d pressure results, %0d divide faults",
               n_temp, n_press, n_fault);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("tb: errors");
      $finish;
   end
endmodule
